// ----- rtl/core/urxfb_pkg.sv -----
`default_nettype none

package urxfb_pkg;

    // Transaction action codes
    typedef enum logic [1:0] {
        ACT_BYTE    = 2'd0,
        ACT_TICK    = 2'd1,
        ACT_READ    = 2'd2,
        ACT_RELEASE = 2'd3
    } action_t;

    // Buffer state, one-hot
    typedef enum logic [2:0] {
        ST_EMPTY     = 3'b001,
        ST_RECEIVING = 3'b010,
        ST_READY     = 3'b100
    } buf_state_t;

    // Encoded buffer state as seen on the result channel
    localparam logic [1:0] BUF_EMPTY     = 2'd0;
    localparam logic [1:0] BUF_RECEIVING = 2'd1;
    localparam logic [1:0] BUF_READY     = 2'd2;

    localparam logic [15:0] IDLE_TIMEOUT_RESET = 16'd1000;
    localparam logic [15:0] IDLE_COUNT_MAX     = 16'hFFFF;

    function automatic logic [1:0] encode_state(buf_state_t st);
        logic [1:0] code;
        case (st)
            ST_EMPTY:     code = BUF_EMPTY;
            ST_RECEIVING: code = BUF_RECEIVING;
            ST_READY:     code = BUF_READY;
            default:      code = BUF_EMPTY;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/urxfb_store.sv -----
`default_nettype none

module urxfb_store #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    // Write the received byte
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, loaded together with the result register
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/core/uart_rx_frame_buffer_idle_timeout.sv -----
`default_nettype none

// UART receive frame buffer with idle-timeout framing. Each transaction (byte,
// timer tick, read, release) gives exactly one result transaction. The block
// takes one transaction per cycle while the result channel is not stalled. A
// transaction is held in the input register until the result register can take it;
// then the state update and the frame store access (one write port, one registered
// read port) load the result register, which presents the result on the m_ ports.
// A stalled result register holds the input stage, and ready falls only when both
// stages are full. The frame closes when the stored total reaches FRAME_DEPTH-1 or
// when the idle ticks since the last byte reach idle_timeout_ticks (reset 1000),
// written through cfg_we/cfg_wdata; the user must write it only while idle, which the
// block does not enforce. Reads of positions at or above the total return zero.
module uart_rx_frame_buffer_idle_timeout #(
    parameter int FRAME_DEPTH = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_action,
    input  wire logic [7:0]  s_rx_byte,
    input  wire logic        s_rx_error,
    input  wire logic [7:0]  s_read_index,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_buffer_state,
    output logic [7:0]       m_total_count,
    output logic [7:0]       m_good_count,
    output logic [7:0]       m_bad_count,
    output logic [7:0]       m_read_data,
    output logic             m_frame_done
);

    import urxfb_pkg::*;

    localparam int AW   = $clog2(FRAME_DEPTH);
    localparam int CMPW = (AW > 8) ? AW : 8;
    localparam logic [AW-1:0] LAST_TOTAL = AW'(FRAME_DEPTH - 1);

    // Input stage
    logic          a_valid_reg;
    action_t       a_action_reg;
    logic [7:0]    a_byte_reg;
    logic          a_error_reg;
    logic [7:0]    a_index_reg;

    // Block state
    buf_state_t    state_reg, state_next;
    logic [AW-1:0] total_reg, total_next;
    logic [AW-1:0] good_reg, good_next;
    logic [AW-1:0] bad_reg, bad_next;
    logic [15:0]   idle_cnt_reg, idle_cnt_next;
    logic          idle_run_reg, idle_run_next;
    logic [15:0]   timeout_reg;

    // Result stage
    logic          hit_reg, hit_next;
    logic          done_reg, done_next;
    logic [1:0]    bstate_reg;
    logic [AW-1:0] out_total_reg, out_good_reg, out_bad_reg;

    logic          out_load;
    logic          mem_we;
    logic [7:0]    mem_rdata;

    assign out_load = a_valid_reg && (!m_valid || m_ready);
    assign s_ready  = !a_valid_reg || out_load;

    // Capture the incoming transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_ready) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            a_action_reg <= action_t'(s_action);
            a_byte_reg   <= s_rx_byte;
            a_error_reg  <= s_rx_error;
            a_index_reg  <= s_read_index;
        end
    end

    // Hold the idle timeout setting
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= IDLE_TIMEOUT_RESET;
        end else if (cfg_we) begin
            timeout_reg <= cfg_wdata;
        end
    end

    // Apply one transaction to the buffer state
    always_comb begin
        state_next    = state_reg;
        total_next    = total_reg;
        good_next     = good_reg;
        bad_next      = bad_reg;
        idle_cnt_next = idle_cnt_reg;
        idle_run_next = idle_run_reg;
        done_next     = 1'b0;
        hit_next      = 1'b0;
        mem_we        = 1'b0;
        case (a_action_reg)
            ACT_BYTE: begin
                if (state_reg == ST_EMPTY) begin
                    total_next    = '0;
                    good_next     = '0;
                    bad_next      = '0;
                    state_next    = ST_RECEIVING;
                    idle_run_next = 1'b1;
                end
                if (state_next == ST_RECEIVING) begin
                    mem_we = 1'b1;
                    if (a_error_reg) begin
                        bad_next = bad_next + 1'b1;
                    end else begin
                        good_next = good_next + 1'b1;
                    end
                    total_next = total_next + 1'b1;
                    if (total_next == LAST_TOTAL) begin
                        state_next    = ST_READY;
                        idle_run_next = 1'b0;
                        done_next     = 1'b1;
                    end
                end
                idle_cnt_next = '0;
            end
            ACT_TICK: begin
                if (idle_run_reg) begin
                    if (idle_cnt_reg != IDLE_COUNT_MAX) begin
                        idle_cnt_next = idle_cnt_reg + 1'b1;
                    end
                    if (idle_cnt_next >= timeout_reg) begin
                        state_next    = ST_READY;
                        idle_run_next = 1'b0;
                        idle_cnt_next = '0;
                        done_next     = 1'b1;
                    end
                end
            end
            ACT_READ: begin
                hit_next = CMPW'(a_index_reg) < CMPW'(total_reg);
            end
            ACT_RELEASE: begin
                state_next    = ST_EMPTY;
                idle_run_next = 1'b0;
                idle_cnt_next = '0;
            end
            default: begin
                state_next = state_reg;
            end
        endcase
    end

    // Advance the buffer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_EMPTY;
            total_reg    <= '0;
            good_reg     <= '0;
            bad_reg      <= '0;
            idle_cnt_reg <= '0;
            idle_run_reg <= 1'b0;
        end else if (out_load) begin
            state_reg    <= state_next;
            total_reg    <= total_next;
            good_reg     <= good_next;
            bad_reg      <= bad_next;
            idle_cnt_reg <= idle_cnt_next;
            idle_run_reg <= idle_run_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (out_load) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            bstate_reg    <= encode_state(state_next);
            out_total_reg <= total_next;
            out_good_reg  <= good_next;
            out_bad_reg   <= bad_next;
            hit_reg       <= hit_next;
            done_reg      <= done_next;
        end
    end

    urxfb_store #(
        .DEPTH (FRAME_DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk  (aclk),
        .we    (out_load && mem_we),
        .waddr (total_next - 1'b1),
        .wdata (a_byte_reg),
        .re    (out_load),
        .raddr (AW'(a_index_reg)),
        .rdata (mem_rdata)
    );

    assign m_buffer_state = bstate_reg;
    assign m_total_count  = 8'(out_total_reg);
    assign m_good_count   = 8'(out_good_reg);
    assign m_bad_count    = 8'(out_bad_reg);
    assign m_read_data    = hit_reg ? mem_rdata : 8'd0;
    assign m_frame_done   = done_reg;

endmodule

`default_nettype wire

// ----- rtl/core/urxfb_checker.sv -----
`default_nettype none

module urxfb_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [1:0]  m_buffer_state,
    input wire logic [7:0]  m_total_count,
    input wire logic [7:0]  m_good_count,
    input wire logic [7:0]  m_bad_count,
    input wire logic [7:0]  m_read_data,
    input wire logic        m_frame_done
);

    import urxfb_pkg::*;

    // A closing transaction always reports the Ready state
    a_done_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_done |-> m_buffer_state == BUF_READY)
        else $error("frame_done without Ready state");

    // Every stored byte is counted either good or bad
    a_count_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_total_count == 8'(m_good_count + m_bad_count))
        else $error("total count differs from good plus bad");

    // A stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_total_count)
            && $stable(m_buffer_state) && $stable(m_read_data)
            && $stable(m_frame_done))
        else $error("result changed while stalled");

    // Reset drops any pending result
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind uart_rx_frame_buffer_idle_timeout urxfb_checker u_checker (.*);

`default_nettype wire
